>>> design/ssc_pkg.sv
// ---------------------------------------------------------------------------
// Spacing speed controller package
// Shared widths, register indexes, reset values and structs for the spacing
// speed controller.
// ---------------------------------------------------------------------------
package ssc_pkg;

	localparam int AGENTS     = 64;
	localparam int HOLD_STEPS = 50;

	localparam int ID_W    = 6;
	localparam int GAP_W   = 24;
	localparam int SPD_W   = 16;
	localparam int GAIN_W  = 16;
	localparam int TMR_W   = 10;
	localparam int Q_FRAC  = 12;
	localparam int ADDR_W  = 6;
	localparam int DATA_W  = 64;
	localparam int REG_IDX_W = 3;

	localparam int AGT_IDX_W = (AGENTS >= (1 << ID_W)) ? ID_W :
		((AGENTS > 1) ? $clog2(AGENTS) : 1);

	localparam logic [TMR_W-1:0] HOLD_LOAD = TMR_W'(HOLD_STEPS);

	localparam logic [REG_IDX_W-1:0] REG_NOMINAL   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAX       = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_REC_CAP   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_REC_FRONT = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_REC_BACK  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SAFE_GAP  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SAFE_SLP  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_GAINS     = 3'd7;

	localparam logic [SPD_W-1:0]    RST_NOMINAL   = 16'd256;
	localparam logic [SPD_W-1:0]    RST_MAX       = 16'd512;
	localparam logic [SPD_W-1:0]    RST_REC_CAP   = 16'd384;
	localparam logic [GAP_W-1:0]    RST_REC_FRONT = 24'd1536;
	localparam logic [GAP_W-1:0]    RST_REC_BACK  = 24'd1024;
	localparam logic [GAP_W-1:0]    RST_SAFE_GAP  = 24'd256;
	localparam logic [GAIN_W-1:0]   RST_SAFE_SLP  = 16'd4096;
	localparam logic [3*GAIN_W-1:0] RST_GAINS     = 48'h030D_4023_8800;

	typedef struct packed {
		logic [SPD_W-1:0]  nominal_speed;
		logic [SPD_W-1:0]  max_speed;
		logic [SPD_W-1:0]  recovery_cap;
		logic [GAP_W-1:0]  recovery_front_gap;
		logic [GAP_W-1:0]  recovery_back_gap;
		logic [GAP_W-1:0]  safe_gap;
		logic [GAIN_W-1:0] safe_slope;
		logic [GAIN_W-1:0] k_sym;
		logic [GAIN_W-1:0] k_rec;
		logic [GAIN_W-1:0] k_rep;
	} cfg_t;

	typedef struct packed {
		logic            rd_en;
		logic [ID_W-1:0] rd_id;
		logic            wr_en;
		logic [ID_W-1:0] wr_id;
		logic            spare;
	} hold_req_t;

endpackage

>>> design/spacing_speed_controller.sv
// ---------------------------------------------------------------------------
// Spacing speed controller
// Per-agent ring spacing speed law with hold timers for new spares.
// ---------------------------------------------------------------------------
// One agent update is taken in every cycle in which in_stall is low. The
// transfer loads the input register and reads the agent's hold timer from a
// 64-entry memory; the result register is loaded from the input register,
// once no result is stalled at the output, after the speed law and the timer
// write-back, and the result is offered from the result register. Updates of
// the same agent in consecutive cycles see each other's timer through a
// bypass. Hold timers come out of reset at zero through per-entry valid bits,
// so no clearing pass is needed. The input side stalls only while a result is
// stalled at the output and the input register is full.
module spacing_speed_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ssc_pkg::ADDR_W-1:0]    paddr,
	input  logic [ssc_pkg::DATA_W-1:0]    pwdata,
	output logic [ssc_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ssc_pkg::ID_W-1:0]      agent_id,
	input  logic [ssc_pkg::GAP_W-1:0]     front_gap,
	input  logic [ssc_pkg::GAP_W-1:0]     back_gap,
	input  logic                          spare_start,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ssc_pkg::ID_W-1:0]      agent_out,
	output logic [ssc_pkg::SPD_W-1:0]     speed,
	output logic                          recovering,
	output logic                          holding
);

	ssc_pkg::cfg_t      cfg;
	ssc_pkg::hold_req_t hreq;

	logic                        vld_s1;
	logic [ssc_pkg::ID_W-1:0]    agent_s1;
	logic [ssc_pkg::GAP_W-1:0]   front_s1;
	logic [ssc_pkg::GAP_W-1:0]   back_s1;
	logic                        spare_s1;

	logic                        vld_s2;
	logic [ssc_pkg::ID_W-1:0]    agent_s2;
	logic [ssc_pkg::SPD_W-1:0]   speed_s2;
	logic                        rec_s2;
	logic                        hold_s2;

	logic                        adv_s1;
	logic                        take;
	logic                        hold_now;
	logic [ssc_pkg::SPD_W-1:0]   speed_now;
	logic                        rec_now;

	assign pready = 1'b1;

	assign adv_s1   = !(vld_s2 && out_stall);
	assign in_stall = vld_s1 && !adv_s1;
	assign take     = in_valid && !in_stall;

	always_comb begin
		hreq.rd_en = take;
		hreq.rd_id = agent_id;
		hreq.wr_en = vld_s1 && adv_s1;
		hreq.wr_id = agent_s1;
		hreq.spare = spare_s1;
	end

	ssc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	ssc_hold u_hold (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (hreq),
		.holding (hold_now)
	);

	ssc_law u_law (
		.cfg        (cfg),
		.front_gap  (front_s1),
		.back_gap   (back_s1),
		.holding    (hold_now),
		.speed      (speed_now),
		.recovering (rec_now)
	);

	always_ff @(posedge clk) begin
		if (take) begin
			agent_s1 <= agent_id;
			front_s1 <= front_gap;
			back_s1  <= back_gap;
			spare_s1 <= spare_start;
		end
		if (vld_s1 && adv_s1) begin
			agent_s2 <= agent_s1;
			speed_s2 <= speed_now;
			rec_s2   <= rec_now;
			hold_s2  <= hold_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (take) begin
				vld_s1 <= 1'b1;
			end else if (adv_s1) begin
				vld_s1 <= 1'b0;
			end
			if (adv_s1) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	assign out_valid  = vld_s2;
	assign agent_out  = agent_s2;
	assign speed      = speed_s2;
	assign recovering = rec_s2;
	assign holding    = hold_s2;

endmodule

>>> design/ssc_regs.sv
// ---------------------------------------------------------------------------
// Spacing speed controller register file
// APB-style configuration registers holding the speed law settings.
// ---------------------------------------------------------------------------
module ssc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ssc_pkg::ADDR_W-1:0]    paddr,
	input  logic [ssc_pkg::DATA_W-1:0]    pwdata,
	output logic [ssc_pkg::DATA_W-1:0]    prdata,
	output ssc_pkg::cfg_t                 cfg
);

	logic [ssc_pkg::SPD_W-1:0]    nominal_q;
	logic [ssc_pkg::SPD_W-1:0]    max_q;
	logic [ssc_pkg::SPD_W-1:0]    rec_cap_q;
	logic [ssc_pkg::GAP_W-1:0]    rec_front_q;
	logic [ssc_pkg::GAP_W-1:0]    rec_back_q;
	logic [ssc_pkg::GAP_W-1:0]    safe_gap_q;
	logic [ssc_pkg::GAIN_W-1:0]   safe_slope_q;
	logic [3*ssc_pkg::GAIN_W-1:0] gains_q;
	logic [ssc_pkg::REG_IDX_W-1:0] idx;
	logic                          wr;

	assign idx = paddr[ssc_pkg::ADDR_W-1:3];
	assign wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nominal_q    <= ssc_pkg::RST_NOMINAL;
			max_q        <= ssc_pkg::RST_MAX;
			rec_cap_q    <= ssc_pkg::RST_REC_CAP;
			rec_front_q  <= ssc_pkg::RST_REC_FRONT;
			rec_back_q   <= ssc_pkg::RST_REC_BACK;
			safe_gap_q   <= ssc_pkg::RST_SAFE_GAP;
			safe_slope_q <= ssc_pkg::RST_SAFE_SLP;
			gains_q      <= ssc_pkg::RST_GAINS;
		end else if (wr) begin
			case (idx)
				ssc_pkg::REG_NOMINAL:   nominal_q    <= pwdata[ssc_pkg::SPD_W-1:0];
				ssc_pkg::REG_MAX:       max_q        <= pwdata[ssc_pkg::SPD_W-1:0];
				ssc_pkg::REG_REC_CAP:   rec_cap_q    <= pwdata[ssc_pkg::SPD_W-1:0];
				ssc_pkg::REG_REC_FRONT: rec_front_q  <= pwdata[ssc_pkg::GAP_W-1:0];
				ssc_pkg::REG_REC_BACK:  rec_back_q   <= pwdata[ssc_pkg::GAP_W-1:0];
				ssc_pkg::REG_SAFE_GAP:  safe_gap_q   <= pwdata[ssc_pkg::GAP_W-1:0];
				ssc_pkg::REG_SAFE_SLP:  safe_slope_q <= pwdata[ssc_pkg::GAIN_W-1:0];
				ssc_pkg::REG_GAINS:     gains_q      <= pwdata[3*ssc_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			ssc_pkg::REG_NOMINAL:   prdata = ssc_pkg::DATA_W'(nominal_q);
			ssc_pkg::REG_MAX:       prdata = ssc_pkg::DATA_W'(max_q);
			ssc_pkg::REG_REC_CAP:   prdata = ssc_pkg::DATA_W'(rec_cap_q);
			ssc_pkg::REG_REC_FRONT: prdata = ssc_pkg::DATA_W'(rec_front_q);
			ssc_pkg::REG_REC_BACK:  prdata = ssc_pkg::DATA_W'(rec_back_q);
			ssc_pkg::REG_SAFE_GAP:  prdata = ssc_pkg::DATA_W'(safe_gap_q);
			ssc_pkg::REG_SAFE_SLP:  prdata = ssc_pkg::DATA_W'(safe_slope_q);
			ssc_pkg::REG_GAINS:     prdata = ssc_pkg::DATA_W'(gains_q);
			default:                prdata = '0;
		endcase
	end

	always_comb begin
		cfg.nominal_speed      = nominal_q;
		cfg.max_speed          = max_q;
		cfg.recovery_cap       = rec_cap_q;
		cfg.recovery_front_gap = rec_front_q;
		cfg.recovery_back_gap  = rec_back_q;
		cfg.safe_gap           = safe_gap_q;
		cfg.safe_slope         = safe_slope_q;
		cfg.k_sym              = gains_q[ssc_pkg::GAIN_W-1:0];
		cfg.k_rec              = gains_q[2*ssc_pkg::GAIN_W-1:ssc_pkg::GAIN_W];
		cfg.k_rep              = gains_q[3*ssc_pkg::GAIN_W-1:2*ssc_pkg::GAIN_W];
	end

endmodule

>>> design/ssc_hold.sv
// ---------------------------------------------------------------------------
// Spacing speed controller hold timers
// Per-agent hold timer memory with valid bits, read when a transfer is
// taken and written back when that item leaves the input register.
// ---------------------------------------------------------------------------
module ssc_hold (
	input  logic               clk,
	input  logic               arst_n,
	input  ssc_pkg::hold_req_t req,
	output logic               holding
);

	logic [ssc_pkg::TMR_W-1:0] mem [ssc_pkg::AGENTS];
	logic [ssc_pkg::AGENTS-1:0] vld_q;

	logic [ssc_pkg::TMR_W-1:0] rd_data_s1;
	logic                      rd_vld_s1;
	logic                      rd_ok_s1;
	logic                      fwd_s1;
	logic [ssc_pkg::TMR_W-1:0] fwd_val_s1;

	logic [ssc_pkg::TMR_W-1:0] cur;
	logic [ssc_pkg::TMR_W-1:0] loaded;
	logic [ssc_pkg::TMR_W-1:0] nxt;
	logic                      rd_in_range;
	logic                      wr_hit;

	assign rd_in_range = ({1'b0, req.rd_id} < (ssc_pkg::ID_W+1)'(ssc_pkg::AGENTS));

	always_comb begin
		if (fwd_s1) begin
			cur = fwd_val_s1;
		end else if (rd_vld_s1) begin
			cur = rd_data_s1;
		end else begin
			cur = '0;
		end
		loaded  = req.spare ? ssc_pkg::HOLD_LOAD : cur;
		holding = rd_ok_s1 && (loaded != '0);
		nxt     = holding ? loaded - 1'b1 : loaded;
	end

	assign wr_hit = req.wr_en && rd_ok_s1;

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			mem[req.wr_id[ssc_pkg::AGT_IDX_W-1:0]] <= nxt;
		end
		if (req.rd_en) begin
			rd_data_s1 <= mem[req.rd_id[ssc_pkg::AGT_IDX_W-1:0]];
			fwd_val_s1 <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
			rd_ok_s1  <= 1'b0;
			fwd_s1    <= 1'b0;
		end else begin
			if (wr_hit) begin
				vld_q[req.wr_id[ssc_pkg::AGT_IDX_W-1:0]] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_s1 <= vld_q[req.rd_id[ssc_pkg::AGT_IDX_W-1:0]];
				rd_ok_s1  <= rd_in_range;
				fwd_s1    <= wr_hit && (req.wr_id == req.rd_id);
			end
		end
	end

endmodule

>>> design/ssc_law.sv
// ---------------------------------------------------------------------------
// Spacing speed controller speed law
// Recovery detection, gain term, front cap, back repulsion, recovery cap,
// final clamp and hold override for one agent.
// ---------------------------------------------------------------------------
module ssc_law (
	input  ssc_pkg::cfg_t              cfg,
	input  logic [ssc_pkg::GAP_W-1:0]  front_gap,
	input  logic [ssc_pkg::GAP_W-1:0]  back_gap,
	input  logic                       holding,
	output logic [ssc_pkg::SPD_W-1:0]  speed,
	output logic                       recovering
);

	localparam int DLT_W  = ssc_pkg::GAP_W + 1;
	localparam int GPR_W  = ssc_pkg::GAIN_W + 1 + DLT_W;
	localparam int UPR_W  = ssc_pkg::GAIN_W + ssc_pkg::GAP_W;
	localparam int V_W    = 32;

	logic [ssc_pkg::GAIN_W-1:0] k;
	logic signed [DLT_W-1:0]    delta;
	logic signed [GPR_W-1:0]    gprod;
	logic [UPR_W-1:0]           cprod;
	logic [UPR_W-1:0]           rprod;
	logic [ssc_pkg::GAP_W-1:0]  rdiff;
	logic signed [V_W-1:0]      v0;
	logic signed [V_W-1:0]      v1;
	logic signed [V_W-1:0]      v2;
	logic signed [V_W-1:0]      v3;
	logic signed [V_W-1:0]      cap;
	logic signed [V_W-1:0]      rep;
	logic signed [V_W-1:0]      rcap;
	logic signed [V_W-1:0]      vmax;
	logic                       front_close;
	logic                       back_close;

	always_comb begin
		recovering = (front_gap > cfg.recovery_front_gap) ||
			(back_gap < cfg.recovery_back_gap);
		k = (recovering && (cfg.k_rec != '0)) ? cfg.k_rec : cfg.k_sym;

		delta = $signed({1'b0, front_gap}) - $signed({1'b0, back_gap});
		gprod = $signed({1'b0, k}) * delta;
		v0 = $signed(V_W'(cfg.nominal_speed)) +
			V_W'($signed(gprod[GPR_W-1:ssc_pkg::Q_FRAC]));

		front_close = front_gap < cfg.safe_gap;
		cprod = UPR_W'(cfg.safe_slope) * UPR_W'(front_gap);
		cap   = $signed(V_W'(cprod[UPR_W-1:ssc_pkg::Q_FRAC]));
		v1    = (front_close && (v0 > cap)) ? cap : v0;

		back_close = back_gap < cfg.safe_gap;
		rdiff = cfg.safe_gap - back_gap;
		rprod = UPR_W'(cfg.k_rep) * UPR_W'(rdiff);
		rep   = back_close ? $signed(V_W'(rprod[UPR_W-1:ssc_pkg::Q_FRAC])) : '0;
		v2    = v1 + rep;

		rcap = $signed(V_W'(cfg.recovery_cap));
		vmax = $signed(V_W'(cfg.max_speed));
		v3   = (recovering && (v2 > rcap)) ? rcap : v2;

		if (holding) begin
			speed = cfg.nominal_speed;
		end else if (v3 < 0) begin
			speed = '0;
		end else if (v3 > vmax) begin
			speed = cfg.max_speed;
		end else begin
			speed = v3[ssc_pkg::SPD_W-1:0];
		end
	end

endmodule

>>> design/ssc_checker.sv
// ---------------------------------------------------------------------------
// Spacing speed controller port checker
// Concurrent checks on the top level's ports, bound to the top level.
// ---------------------------------------------------------------------------
module ssc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [ssc_pkg::SPD_W-1:0] speed,
	input logic                      holding
);

	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	a_out_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(speed) && $stable(holding))
		else $error("stalled result changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall |=> out_valid)
		else $error("accepted transfer produced no result");

endmodule

bind spacing_speed_controller ssc_checker u_ssc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.speed     (speed),
	.holding   (holding)
);
